// ===== hdl/pcsc_pkg.sv =====
// Shared types, constants and helper functions for the pixel color space converter.
// Every module of the converter uses this package; it depends on nothing else.
package pcsc_pkg;

	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_W = COEF_FRAC_BITS + 2;
	localparam int OPND_W = 9;
	localparam int PROD_W = COEF_W + OPND_W;
	localparam int SUM_W = PROD_W + 2;
	localparam int NUM_PROD = 9;

	localparam logic [1:0] MODE_RGB2YCC = 2'd0;
	localparam logic [1:0] MODE_YCC2RGB = 2'd1;
	localparam logic [1:0] MODE_EXPAND = 2'd2;

	// Coefficients held with 24 fractional bits.
	localparam longint K_Y_R = 64'sd5016388;
	localparam longint K_Y_G = 64'sd9848226;
	localparam longint K_Y_B = 64'sd1912603;
	localparam longint K_CB_R = 64'sd2830920;
	localparam longint K_CB_G = 64'sd5557688;
	localparam longint K_HALF = 64'sd8388608;
	localparam longint K_CR_G = 64'sd7024419;
	localparam longint K_CR_B = 64'sd1364189;
	localparam longint K_R_CR = 64'sd23521657;
	localparam longint K_G_CB = 64'sd5773644;
	localparam longint K_G_CR = 64'sd11981214;
	localparam longint K_B_CB = 64'sd29729227;

	// Rounds a 24-bit fraction to COEF_FRAC_BITS, ties upward.
	function automatic logic signed [COEF_W-1:0] coef(input longint k24);
		return COEF_W'((((k24 <<< 1) >>> (24 - COEF_FRAC_BITS)) + 64'sd1) >>> 1);
	endfunction

	localparam logic signed [COEF_W-1:0] C_Y_R = coef(K_Y_R);
	localparam logic signed [COEF_W-1:0] C_Y_G = coef(K_Y_G);
	localparam logic signed [COEF_W-1:0] C_Y_B = coef(K_Y_B);
	localparam logic signed [COEF_W-1:0] C_CB_R = coef(K_CB_R);
	localparam logic signed [COEF_W-1:0] C_CB_G = coef(K_CB_G);
	localparam logic signed [COEF_W-1:0] C_HALF = coef(K_HALF);
	localparam logic signed [COEF_W-1:0] C_CR_G = coef(K_CR_G);
	localparam logic signed [COEF_W-1:0] C_CR_B = coef(K_CR_B);
	localparam logic signed [COEF_W-1:0] C_R_CR = coef(K_R_CR);
	localparam logic signed [COEF_W-1:0] C_G_CB = coef(K_G_CB);
	localparam logic signed [COEF_W-1:0] C_G_CR = coef(K_G_CR);
	localparam logic signed [COEF_W-1:0] C_B_CB = coef(K_B_CB);

	localparam logic signed [SUM_W-1:0] OFFSET = SUM_W'(128) <<< COEF_FRAC_BITS;

	typedef struct packed {
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
		logic [7:0] alpha_in;
		logic [15:0] packed_pixel;
	} in_t;

	typedef struct packed {
		logic [7:0] out_a;
		logic [7:0] out_b;
		logic [7:0] out_c;
		logic [7:0] alpha_out;
	} out_t;

	// Per-pixel context carried alongside the arithmetic.
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] alpha;
		logic [7:0] luma;
		logic [14:0] pix;
	} side_t;

	typedef logic [NUM_PROD-1:0][PROD_W-1:0] prod_vec_t;
	typedef logic [2:0][SUM_W-1:0] sum_vec_t;

	function automatic logic signed [SUM_W-1:0] widen(input logic [PROD_W-1:0] p);
		return SUM_W'($signed(p));
	endfunction

endpackage

// ===== hdl/pcsc_mul.sv =====
// First stage: selects operands per mode and registers the nine coefficient products.
// Depends on pcsc_pkg.
module pcsc_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid,
	input  pcsc_pkg::in_t       data,
	input  logic [1:0]          mode,
	output logic                valid_s1,
	output pcsc_pkg::prod_vec_t prod_s1,
	output pcsc_pkg::side_t     side_s1
);

	logic                                  ycc;
	logic signed [pcsc_pkg::OPND_W-1:0]    a9, b9, c9, db9, dr9;
	logic signed [pcsc_pkg::OPND_W-1:0]    opnd [pcsc_pkg::NUM_PROD];
	logic signed [pcsc_pkg::COEF_W-1:0]    cf [pcsc_pkg::NUM_PROD];
	pcsc_pkg::prod_vec_t                   prod;

	always_comb begin
		ycc = (mode == pcsc_pkg::MODE_YCC2RGB);
		a9 = $signed({1'b0, data.chan_a});
		b9 = $signed({1'b0, data.chan_b});
		c9 = $signed({1'b0, data.chan_c});
		db9 = b9 - 9'sd128;
		dr9 = c9 - 9'sd128;

		opnd[0] = ycc ? dr9 : a9;
		cf[0] = ycc ? pcsc_pkg::C_R_CR : pcsc_pkg::C_Y_R;
		opnd[1] = ycc ? 9'sd0 : b9;
		cf[1] = pcsc_pkg::C_Y_G;
		opnd[2] = ycc ? 9'sd0 : c9;
		cf[2] = pcsc_pkg::C_Y_B;
		opnd[3] = ycc ? db9 : a9;
		cf[3] = ycc ? pcsc_pkg::C_G_CB : pcsc_pkg::C_CB_R;
		opnd[4] = ycc ? dr9 : b9;
		cf[4] = ycc ? pcsc_pkg::C_G_CR : pcsc_pkg::C_CB_G;
		opnd[5] = ycc ? 9'sd0 : c9;
		cf[5] = pcsc_pkg::C_HALF;
		opnd[6] = ycc ? db9 : a9;
		cf[6] = ycc ? pcsc_pkg::C_B_CB : pcsc_pkg::C_HALF;
		opnd[7] = ycc ? 9'sd0 : b9;
		cf[7] = pcsc_pkg::C_CR_G;
		opnd[8] = ycc ? 9'sd0 : c9;
		cf[8] = pcsc_pkg::C_CR_B;

		for (int i = 0; i < pcsc_pkg::NUM_PROD; i++) begin
			prod[i] = opnd[i] * cf[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			side_s1.mode <= mode;
			side_s1.alpha <= data.alpha_in;
			side_s1.luma <= data.chan_a;
			side_s1.pix <= data.packed_pixel[14:0];
		end
	end

endmodule

// ===== hdl/pcsc_sum.sv =====
// Second stage: adds the products for each channel, with the luma base in YCC-to-RGB mode, else the offset on chroma.
// Depends on pcsc_pkg.
module pcsc_sum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_s1,
	input  pcsc_pkg::prod_vec_t prod_s1,
	input  pcsc_pkg::side_t     side_s1,
	output logic                valid_s2,
	output pcsc_pkg::sum_vec_t  sum_s2,
	output pcsc_pkg::side_t     side_s2
);

	logic signed [pcsc_pkg::SUM_W-1:0] base, x_a, x_bc;
	logic signed [pcsc_pkg::SUM_W-1:0] p [pcsc_pkg::NUM_PROD];
	pcsc_pkg::sum_vec_t                sum;

	always_comb begin
		base = $signed(pcsc_pkg::SUM_W'(side_s1.luma)) <<< pcsc_pkg::COEF_FRAC_BITS;
		for (int i = 0; i < pcsc_pkg::NUM_PROD; i++) begin
			p[i] = pcsc_pkg::widen(prod_s1[i]);
		end
		if (side_s1.mode == pcsc_pkg::MODE_YCC2RGB) begin
			x_a = base;
			x_bc = base;
		end else begin
			x_a = '0;
			x_bc = pcsc_pkg::OFFSET;
		end
		sum[0] = x_a + p[0] + p[1] + p[2];
		sum[1] = x_bc - p[3] - p[4] + p[5];
		sum[2] = x_bc + p[6] - p[7] - p[8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum;
			side_s2 <= side_s1;
		end
	end

endmodule

// ===== hdl/pcsc_out.sv =====
// Third stage: truncates and clamps the sums, applies the per-mode cases and holds the result.
// Depends on pcsc_pkg.
module pcsc_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_s2,
	input  pcsc_pkg::sum_vec_t sum_s2,
	input  pcsc_pkg::side_t    side_s2,
	output logic               valid_s3,
	output pcsc_pkg::out_t     data_s3
);

	pcsc_pkg::out_t res;

	function automatic logic [7:0] clamp(input logic [pcsc_pkg::SUM_W-1:0] t);
		logic [7:0] v;
		if (t[pcsc_pkg::SUM_W-1]) begin
			v = 8'd0;
		end else if (|t[pcsc_pkg::SUM_W-2:pcsc_pkg::COEF_FRAC_BITS+8]) begin
			v = 8'hff;
		end else begin
			v = t[pcsc_pkg::COEF_FRAC_BITS+7:pcsc_pkg::COEF_FRAC_BITS];
		end
		return v;
	endfunction

	function automatic logic [7:0] expand5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	always_comb begin
		res = '0;
		case (side_s2.mode)
			pcsc_pkg::MODE_RGB2YCC: begin
				res.out_a = clamp(sum_s2[0]);
				res.out_b = clamp(sum_s2[1]);
				res.out_c = clamp(sum_s2[2]);
				res.alpha_out = side_s2.alpha;
			end
			pcsc_pkg::MODE_YCC2RGB: begin
				// A transparent pixel comes out all zero; black and white fall out of the sums.
				if (side_s2.alpha != 8'd0) begin
					res.out_a = clamp(sum_s2[0]);
					res.out_b = clamp(sum_s2[1]);
					res.out_c = clamp(sum_s2[2]);
					res.alpha_out = side_s2.alpha;
				end
			end
			pcsc_pkg::MODE_EXPAND: begin
				res.out_a = expand5(side_s2.pix[14:10]);
				res.out_b = expand5(side_s2.pix[9:5]);
				res.out_c = expand5(side_s2.pix[4:0]);
				res.alpha_out = 8'hff;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s3 <= res;
		end
	end

endmodule

// ===== hdl/pixel_color_space_converter_top.sv =====
// Top level of the pixel color space converter: mode register, stage control and the
// three pipeline stages. Depends on pcsc_pkg, pcsc_mul, pcsc_sum and pcsc_out.
//
//   Channel   Signals                          Beat
//   input     in_valid, in_stall, in_data      one pixel (pcsc_pkg::in_t)
//   output    out_valid, out_stall, out_data   one pixel (pcsc_pkg::out_t)
//   config    cfg_wr_en, cfg_wr_data           mode register
//
// A pixel is registered in the product, sum and clamp stages in turn from input beat to output beat,
// and one pixel enters per cycle while in_stall is low.
// Reset clears the mode register to zero and empties all stages.
// A stall holds only the stages that are full behind it; empty stages keep accepting beats.
module pixel_color_space_converter_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  pcsc_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output pcsc_pkg::out_t out_data,
	input  logic           cfg_wr_en,
	input  logic [1:0]     cfg_wr_data
);

	logic [1:0]          mode_q;
	logic                adv1, adv2, adv3;
	logic                valid_s1, valid_s2;
	pcsc_pkg::prod_vec_t prod_s1;
	pcsc_pkg::side_t     side_s1, side_s2;
	pcsc_pkg::sum_vec_t  sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= pcsc_pkg::MODE_RGB2YCC;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	assign adv3 = !out_valid || !out_stall;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign in_stall = !adv1;

	pcsc_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv1),
		.valid    (in_valid),
		.data     (in_data),
		.mode     (mode_q),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1),
		.side_s1  (side_s1)
	);

	pcsc_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv2),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1),
		.side_s1  (side_s1),
		.valid_s2 (valid_s2),
		.sum_s2   (sum_s2),
		.side_s2  (side_s2)
	);

	pcsc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv3),
		.valid_s2 (valid_s2),
		.sum_s2   (sum_s2),
		.side_s2  (side_s2),
		.valid_s3 (out_valid),
		.data_s3  (out_data)
	);

	// The input stalls only when every stage is full and the output is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_valid && out_stall))
		else $error("input stalled with an empty stage");

	// A held first stage keeps its beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv1) |=> valid_s1)
		else $error("stalled first stage lost its beat");

	// A held second stage keeps its beat and its sums.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv2) |=> (valid_s2 && $stable(sum_s2)))
		else $error("stalled second stage changed");

endmodule
